/* rtl/rgbh_pkg.sv */
package rgbh_pkg;

    localparam int CNT_W    = 16;
    localparam int FS_W     = 16;
    localparam int SCALE_W  = 30;
    localparam int X_W      = 32;
    localparam int HNUM_W   = 45;
    localparam int SNUM_W   = 44;
    localparam int Q_W      = 16;
    localparam int HUE_W    = 16;
    localparam int SAT_W    = 14;

    localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd255;
    localparam logic [13:0]     UNIT_SCALE       = 14'd10000;
    localparam logic [12:0]     HUE_SECTOR       = 13'd6000;

    typedef struct packed {
        logic [CNT_W-1:0] red_count;
        logic [CNT_W-1:0] green_count;
        logic [CNT_W-1:0] blue_count;
    } t_rgb_req;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   saturation;
        logic [SCALE_W-1:0] brightness;
    } t_hsv_rsp;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

/* rtl/rgbh_div.sv */
module rgbh_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 16,
    parameter int QW     = 30,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W+DEN_W-1:0] w_ext;
    logic [DEN_W-1:0]       r_rem  [0:QW];
    logic [QW-1:0]          r_acc  [0:QW];
    logic [DEN_W-1:0]       r_den  [0:QW];
    logic [SIDE_W-1:0]      r_side [0:QW];
    logic                   r_vld  [0:QW];

    assign w_ext     = {{DEN_W{1'b0}}, i_num};
    assign r_rem[0]  = w_ext[QW+DEN_W-1:QW];
    assign r_acc[0]  = w_ext[QW-1:0];
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;
    assign r_vld[0]  = i_valid;

    for (genvar gi = 0; gi < QW; gi++) begin : g_stage
        logic [DEN_W:0]   n_sh;
        logic [DEN_W:0]   n_df;
        logic             n_ge;

        always_comb begin
            n_sh = {r_rem[gi], r_acc[gi][QW-1]};
            n_df = n_sh - {1'b0, r_den[gi]};
            n_ge = n_sh >= {1'b0, r_den[gi]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi+1] <= r_vld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi+1]  <= n_ge ? n_df[DEN_W-1:0] : n_sh[DEN_W-1:0];
                r_acc[gi+1]  <= {r_acc[gi][QW-2:0], n_ge};
                r_den[gi+1]  <= r_den[gi];
                r_side[gi+1] <= r_side[gi];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_acc[QW];
    assign o_side  = r_side[QW];

endmodule

/* rtl/rgb_to_hsv_converter_unit.sv */
// RGB to HSV converter.
// Request channel: i_valid / o_stall carrying t_rgb_req (raw 16-bit counts).
// A request is taken at a rising edge with i_valid high and o_stall low.
// Response channel: o_valid / i_stall carrying t_hsv_rsp (hue in 0.01 deg,
// saturation 0..10000, brightness as the scaled maximum channel).
// Configuration: i_cfg_valid / o_cfg_ready with the 16-bit full scale
// divider; o_cfg_ready is always high. Write it only while the pipe is empty.
// Throughput: one request per cycle while o_stall stays low, no gaps between back-to-back requests.
// Pipeline: 51 register stages from request to response. The path is a
// scaling stage, a 30-stage bit-per-cycle divider for the three channel
// scales, three stages for max/min, sector offset and the constant
// products, then two 16-stage dividers for hue and saturation in
// parallel, and the output register.
// Reset clears every valid bit and loads full scale with 255.
// A receiver stall with a response held freezes the whole pipe; nothing
// is dropped or repeated, and the response register holds until taken.
module rgb_to_hsv_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rgbh_pkg::t_rgb_req i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output rgbh_pkg::t_hsv_rsp o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);
    import rgbh_pkg::*;

    logic                en;
    logic [FS_W-1:0]     r_full_scale;

    logic                r0_vld;
    logic [SCALE_W-1:0]  r0_rp, r0_gp, r0_bp;

    logic                w_sv;
    logic [SCALE_W-1:0]  w_rq, w_gq, w_bq;
    logic                w_zr, w_zg, w_zb;

    logic                ra_vld;
    logic [SCALE_W-1:0]  ra_r, ra_g, ra_b, ra_max, ra_diff;
    t_sector             ra_sec;
    logic [SCALE_W-1:0]  n_r, n_g, n_b, n_max, n_min;

    logic                rb_vld;
    logic [X_W-1:0]      rb_x;
    logic [SCALE_W-1:0]  rb_max, rb_diff;
    logic [X_W-1:0]      n_x;

    logic                rc_vld;
    logic [HNUM_W-1:0]   rc_hnum;
    logic [SNUM_W-1:0]   rc_snum;
    logic [SCALE_W-1:0]  rc_max, rc_diff;
    logic                rc_zero;

    logic                w_hv, w_sv2, w_hz;
    logic [Q_W-1:0]      w_hq, w_sq;
    logic [SCALE_W-1:0]  w_smax;

    logic                r_o_valid;
    t_hsv_rsp            r_o_rsp;

    assign en          = !(r_o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_rsp       = r_o_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_full_scale <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r0_vld    <= i_valid;
            ra_vld    <= w_sv;
            rb_vld    <= ra_vld;
            rc_vld    <= rb_vld;
            r_o_valid <= w_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_rp <= SCALE_W'(i_req.red_count) * SCALE_W'(UNIT_SCALE);
            r0_gp <= SCALE_W'(i_req.green_count) * SCALE_W'(UNIT_SCALE);
            r0_bp <= SCALE_W'(i_req.blue_count) * SCALE_W'(UNIT_SCALE);
        end
    end

    rgbh_div #(.NUM_W(SCALE_W), .DEN_W(FS_W), .QW(SCALE_W), .SIDE_W(1)) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_vld),
        .i_num(r0_rp), .i_den(r_full_scale), .i_side(r_full_scale == '0),
        .o_valid(w_sv), .o_quot(w_rq), .o_side(w_zr)
    );

    rgbh_div #(.NUM_W(SCALE_W), .DEN_W(FS_W), .QW(SCALE_W), .SIDE_W(1)) u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_vld),
        .i_num(r0_gp), .i_den(r_full_scale), .i_side(r_full_scale == '0),
        .o_valid(), .o_quot(w_gq), .o_side(w_zg)
    );

    rgbh_div #(.NUM_W(SCALE_W), .DEN_W(FS_W), .QW(SCALE_W), .SIDE_W(1)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_vld),
        .i_num(r0_bp), .i_den(r_full_scale), .i_side(r_full_scale == '0),
        .o_valid(), .o_quot(w_bq), .o_side(w_zb)
    );

    always_comb begin
        n_r = w_zr ? '0 : w_rq;
        n_g = w_zg ? '0 : w_gq;
        n_b = w_zb ? '0 : w_bq;
        n_max = n_r;
        n_min = n_r;
        if (n_g > n_max) n_max = n_g;
        if (n_b > n_max) n_max = n_b;
        if (n_g < n_min) n_min = n_g;
        if (n_b < n_min) n_min = n_b;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_r    <= n_r;
            ra_g    <= n_g;
            ra_b    <= n_b;
            ra_max  <= n_max;
            ra_diff <= n_max - n_min;
            if (n_max == n_r) begin
                ra_sec <= SEC_RED;
            end else if (n_max == n_g) begin
                ra_sec <= SEC_GREEN;
            end else begin
                ra_sec <= SEC_BLUE;
            end
        end
    end

    always_comb begin
        n_x = '0;
        unique case (ra_sec)
            SEC_RED: begin
                if (ra_g > ra_b) begin
                    n_x = X_W'(ra_g) - X_W'(ra_b);
                end else if (ra_b > ra_g) begin
                    n_x = X_W'(ra_g) + X_W'(ra_diff) * X_W'(6) - X_W'(ra_b);
                end
            end
            SEC_GREEN: n_x = X_W'(ra_b) + (X_W'(ra_diff) << 1) - X_W'(ra_r);
            SEC_BLUE:  n_x = X_W'(ra_r) + (X_W'(ra_diff) << 2) - X_W'(ra_g);
            default:   n_x = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_x    <= n_x;
            rb_max  <= ra_max;
            rb_diff <= ra_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_hnum <= HNUM_W'(rb_x) * HNUM_W'(HUE_SECTOR);
            rc_snum <= SNUM_W'(rb_diff) * SNUM_W'(UNIT_SCALE);
            rc_max  <= rb_max;
            rc_diff <= rb_diff;
            rc_zero <= rb_diff == '0;
        end
    end

    rgbh_div #(.NUM_W(HNUM_W), .DEN_W(SCALE_W), .QW(Q_W), .SIDE_W(1)) u_div_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(rc_vld),
        .i_num(rc_hnum), .i_den(rc_diff), .i_side(rc_zero),
        .o_valid(w_hv), .o_quot(w_hq), .o_side(w_hz)
    );

    rgbh_div #(.NUM_W(SNUM_W), .DEN_W(SCALE_W), .QW(Q_W), .SIDE_W(SCALE_W)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(rc_vld),
        .i_num(rc_snum), .i_den(rc_max), .i_side(rc_max),
        .o_valid(w_sv2), .o_quot(w_sq), .o_side(w_smax)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_rsp.brightness <= w_smax;
            if (w_hz || !w_sv2) begin
                r_o_rsp.hue        <= '0;
                r_o_rsp.saturation <= '0;
            end else begin
                r_o_rsp.saturation <= w_sq[SAT_W-1:0];
                r_o_rsp.hue        <= (w_sq == '0) ? '0 : w_hq;
            end
        end
    end

endmodule

/* bench/hsv_checker.sv */
`timescale 1ns / 1ps

module hsv_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  rgbh_pkg::t_rgb_req  i_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  rgbh_pkg::t_hsv_rsp  i_rsp,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);
    import rgbh_pkg::*;

    logic [15:0] full_scale_q;
    t_hsv_rsp    hsv_expected_q[$];

    function automatic logic [63:0] scale_channel(logic [15:0] c, logic [15:0] fs);
        if (fs == 0) return 0;
        return (64'(c) * 64'(UNIT_SCALE)) / 64'(fs);
    endfunction

    function automatic t_hsv_rsp convert_rgb(t_rgb_req req, logic [15:0] fs);
        logic [63:0] r, g, b, cmax, cmin, diff, hue, sat;
        t_hsv_rsp    rsp;
        r = scale_channel(req.red_count, fs);
        g = scale_channel(req.green_count, fs);
        b = scale_channel(req.blue_count, fs);
        cmax = r;
        cmin = r;
        if (g > cmax) cmax = g;
        if (b > cmax) cmax = b;
        if (g < cmin) cmin = g;
        if (b < cmin) cmin = b;
        diff = cmax - cmin;
        hue = 0;
        sat = 0;
        if (diff != 0) begin
            if (cmax == r) begin
                if (g > b) hue = ((g - b) * HUE_SECTOR) / diff;
                else if (b > g) hue = ((g + 6 * diff - b) * HUE_SECTOR) / diff;
            end else if (cmax == g) begin
                hue = ((b + 2 * diff - r) * HUE_SECTOR) / diff;
            end else begin
                hue = ((r + 4 * diff - g) * HUE_SECTOR) / diff;
            end
        end
        if (cmax != 0) sat = (diff * UNIT_SCALE) / cmax;
        if (sat == 0) hue = 0;
        rsp.hue = hue[HUE_W-1:0];
        rsp.saturation = sat[SAT_W-1:0];
        rsp.brightness = cmax[SCALE_W-1:0];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_hsv_rsp exp_rsp;
        if (!i_rst_n) begin
            full_scale_q <= FULL_SCALE_RESET;
            o_errors <= 0;
            o_checked <= 0;
            o_pending <= 0;
            hsv_expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) full_scale_q <= i_cfg_data;
            if (i_valid && !i_stall_in) hsv_expected_q.push_back(convert_rgb(i_req, full_scale_q));
            if (i_rsp_valid && !i_rsp_stall) begin
                o_checked <= o_checked + 1;
                if (hsv_expected_q.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_rsp = hsv_expected_q.pop_front();
                    if (exp_rsp.hue != i_rsp.hue || exp_rsp.saturation != i_rsp.saturation
                        || exp_rsp.brightness != i_rsp.brightness) begin
                        $display("%0t: mismatch expected h=%0d s=%0d v=%0d actual h=%0d s=%0d v=%0d",
                                 $time, exp_rsp.hue, exp_rsp.saturation, exp_rsp.brightness,
                                 i_rsp.hue, i_rsp.saturation, i_rsp.brightness);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= hsv_expected_q.size();
        end
    end
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import rgbh_pkg::*;

    localparam int LATENCY     = 51;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_rgb_req    i_req = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_hsv_rsp    o_rsp;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    int errors, pending, checked;
    int cycles = 0;
    bit calm = 0;
    bit hold_off = 0;
    int hold_len = 0;
    int sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    rgb_to_hsv_converter_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    hsv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_req(i_req),
        .i_rsp_valid(o_valid), .i_rsp_stall(i_stall), .i_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall bursts, plus one long hold-off
    initial begin
        int n;
        @(posedge i_rst_n);
        while (1) begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
                repeat (hold_len) @(negedge i_clk);
                hold_off = 0;
                i_stall <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 18);
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic send_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int n;
        if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            i_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1;
        i_req <= '{red_count: r, green_count: g, blue_count: b};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain_pipe();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_full_scale(logic [15:0] fs);
        i_cfg_valid <= 1;
        i_cfg_data <= fs;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_rgb(int count, logic [15:0] lim);
        logic [15:0] r, g, b;
        repeat (count) begin
            r = 16'($urandom_range(0, lim));
            g = 16'($urandom_range(0, lim));
            b = 16'($urandom_range(0, lim));
            case ($urandom_range(0, 7))
                0: g = b;
                1: r = g;
                2: begin g = r; b = r; end
                3: r = 16'hffff;
                4: r = 16'($urandom);
                default: ;
            endcase
            send_rgb(r, g, b);
        end
    endtask

    initial begin
        logic [15:0] scales[6];
        scales = '{16'd1, 16'd255, 16'd65535, 16'd1023, 16'd0, 16'd4096};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_rgb(16'd0, 16'd0, 16'd0);
        send_rgb(16'hffff, 16'hffff, 16'hffff);
        send_rgb(16'd255, 16'd0, 16'd0);
        send_rgb(16'd0, 16'd255, 16'd0);
        send_rgb(16'd0, 16'd0, 16'd255);
        send_rgb(16'd255, 16'd100, 16'd100);
        send_rgb(16'd255, 16'd200, 16'd50);
        send_rgb(16'd255, 16'd50, 16'd200);
        send_rgb(16'd100, 16'd255, 16'd30);
        send_rgb(16'd100, 16'd30, 16'd255);
        send_rgb(16'd255, 16'd255, 16'd0);
        send_rgb(16'd0, 16'd255, 16'd255);
        send_rgb(16'd255, 16'd0, 16'd255);
        send_rgb(16'hffff, 16'd0, 16'd0);
        send_rgb(16'hffff, 16'hfffe, 16'hfffe);
        send_rgb(16'haaaa, 16'h5555, 16'h0001);
        send_rgb(16'h5555, 16'haaaa, 16'h8000);
        drain_pipe();

        foreach (scales[i]) begin
            write_full_scale(scales[i]);
            random_rgb(60, (scales[i] == 0) ? 16'hffff : scales[i]);
            random_rgb(40, 16'hffff);
            drain_pipe();
        end

        // fill the pipe against a long hold-off
        hold_len = 200;
        hold_off = 1;
        random_rgb(150, 16'hffff);
        drain_pipe();

        write_full_scale(16'd255);
        random_rgb(150, 16'd255);
        calm = 1;
        random_rgb(100, 16'hffff);
        drain_pipe();

        $display("Sent %0d RGB requests over six full-scale settings, %0d responses checked",
                 sent, checked);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
